### rtl/a85d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a85d_pkg
// Shared types and constants of the base-85 stream decoder.
// ----------------------------------------------------------------------------
package a85d_pkg;

   localparam logic [7:0] CHAR_FIRST_DIGIT = 8'h21;   // '!'
   localparam logic [7:0] CHAR_LAST_DIGIT  = 8'h75;   // 'u'
   localparam logic [7:0] CHAR_ZERO_GROUP  = 8'h7a;   // 'z'
   localparam logic [7:0] CHAR_END         = 8'h7e;   // '~'
   localparam logic [7:0] CHAR_SPACE       = 8'h20;   // ' '

   localparam int unsigned MULT_WIDTH = 20;
   localparam logic [MULT_WIDTH-1:0] RADIX    = 20'd85;
   localparam logic [MULT_WIDTH-1:0] RADIX_P2 = 20'd7225;
   localparam logic [MULT_WIDTH-1:0] RADIX_P3 = 20'd614125;

   localparam logic [23:0] PAD_ONE_BYTE    = 24'h0000ff;
   localparam logic [23:0] PAD_TWO_BYTES   = 24'h00ffff;
   localparam logic [23:0] PAD_THREE_BYTES = 24'hffffff;

   typedef enum logic [1:0] {
      STATUS_NORMAL     = 2'd0,
      STATUS_SHORT_TAIL = 2'd1,
      STATUS_BAD_CHAR   = 2'd2
   } a85d_status_type;

   // Decoder state carried from one character to the next.
   typedef struct packed {
      logic [31:0] group_value;
      logic [2:0]  digit_count;
      logic        stream_done;
      logic        stream_failed;
   } a85d_state_type;

   // Bytes produced by one character: a word sent most significant byte first.
   typedef struct packed {
      logic [31:0]     word;
      logic [2:0]      count;
      a85d_status_type status;
   } a85d_burst_type;

endpackage
`default_nettype wire

### rtl/a85d_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a85d_req_if / a85d_rsp_if
// Valid/ready channels for encoded characters in and decoded bytes out.
// ----------------------------------------------------------------------------
interface a85d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

interface a85d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last_of_run;

   modport source (output valid, output data_byte, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input data_byte, input status, input last_of_run,
                   output ready);
endinterface
`default_nettype wire

### rtl/ascii85_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii85_decoder_unit
// Base-85 stream decoder: one character in, zero to four bytes out.
// ----------------------------------------------------------------------------
// Characters arrive on req_if (in_char), one per transfer. Decoded bytes leave
// on rsp_if with a status code and last_of_run marking the final byte caused
// by one character. A bad character gives a single zero byte with error
// status; after the end mark or an error further characters are taken and
// dropped.
// A character taken into the input register is decoded into the output burst
// register, and its first byte is offered from then on.
// Throughput: one character per cycle while the characters produce no bytes;
// a group of bytes leaves one byte per cycle while the receiver is ready, and a
// character that yields bytes holds the decode stage until its last byte leaves,
// since there is a single output burst register.
// Reset clears the decode state and empties both the input register and the
// output burst. When the receiver stalls, the current byte holds, the next
// decoded character waits in the input register and req_if.ready drops.
// ----------------------------------------------------------------------------
module ascii85_decoder_unit
   import a85d_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   a85d_req_if.sink      req_if,
   a85d_rsp_if.source    rsp_if
);

   logic            in_valid_ff;
   logic [7:0]      in_char_ff;
   a85d_state_type  state_ff;
   a85d_state_type  state_in;
   a85d_burst_type  burst_in;
   logic [31:0]     word_ff;
   logic [2:0]      left_ff;
   a85d_status_type status_ff;

   logic req_xfer;
   logic rsp_xfer;
   logic burst_free;
   logic advance;

   a85d_step u_step (
      .in_char    (in_char_ff),
      .state      (state_ff),
      .state_next (state_in),
      .burst      (burst_in)
   );

   assign rsp_xfer   = rsp_if.valid && rsp_if.ready;
   assign burst_free = (left_ff == 3'd0) || (left_ff == 3'd1 && rsp_xfer);
   assign advance    = in_valid_ff && burst_free;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_xfer   = req_if.valid && req_if.ready;

   assign rsp_if.valid       = (left_ff != 3'd0);
   assign rsp_if.data_byte   = word_ff[31:24];
   assign rsp_if.status      = status_ff;
   assign rsp_if.last_of_run = (left_ff == 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         left_ff     <= 3'd0;
         state_ff    <= '0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            left_ff  <= burst_in.count;
            state_ff <= state_in;
         end else if (rsp_xfer) begin
            left_ff <= left_ff - 3'd1;
         end
      end
   end

   // Payload: load a fresh burst, or shift the next byte to the top.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff <= req_if.in_char;
      end
      if (advance) begin
         word_ff   <= burst_in.word;
         status_ff <= burst_in.status;
      end else if (rsp_xfer) begin
         word_ff <= {word_ff[23:0], 8'd0};
      end
   end

   a_no_output_after_stop : assert property (@(posedge clock) disable iff (reset)
      (advance && (state_ff.stream_done || state_ff.stream_failed)) |=> (left_ff == 3'd0))
      else $error("bytes produced after end of stream or error");

   a_error_single_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && status_ff == STATUS_BAD_CHAR) |->
      (rsp_if.data_byte == 8'd0 && rsp_if.last_of_run))
      else $error("error result is not a single zero byte");

   a_digit_count_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.digit_count <= 3'd4)
      else $error("digit count beyond a full group");

endmodule
`default_nettype wire

### rtl/a85d_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// a85d_step
// One decode step: next state and the byte burst caused by one character.
// ----------------------------------------------------------------------------
module a85d_step
   import a85d_pkg::*;
(
   input  wire logic [7:0]     in_char,
   input  wire a85d_state_type state,
   output a85d_state_type      state_next,
   output a85d_burst_type      burst
);

   logic                  is_digit;
   logic [7:0]            digit;
   logic [MULT_WIDTH-1:0] scale;
   logic [23:0]           addend;
   logic [51:0]           product;
   logic [31:0]           word;

   assign is_digit = (in_char >= CHAR_FIRST_DIGIT) && (in_char <= CHAR_LAST_DIGIT);
   assign digit    = in_char - CHAR_FIRST_DIGIT;

   // Digits scale by 85; the end mark pads the missing digits of a tail group.
   always_comb begin
      scale  = RADIX;
      addend = {16'd0, digit};
      if (!is_digit) begin
         case (state.digit_count)
            3'd1, 3'd2: begin
               scale  = RADIX_P3;
               addend = PAD_THREE_BYTES;
            end
            3'd3: begin
               scale  = RADIX_P2;
               addend = PAD_TWO_BYTES;
            end
            default: begin
               scale  = RADIX;
               addend = PAD_ONE_BYTE;
            end
         endcase
      end
   end

   assign product = state.group_value * scale;
   assign word    = product[31:0] + {8'd0, addend};

   always_comb begin
      state_next   = state;
      burst.word   = word;
      burst.count  = 3'd0;
      burst.status = STATUS_NORMAL;
      if (!state.stream_done && !state.stream_failed) begin
         if (is_digit) begin
            if (state.digit_count >= 3'd4) begin
               burst.count             = 3'd4;
               state_next.group_value  = '0;
               state_next.digit_count  = 3'd0;
            end else begin
               state_next.group_value  = word;
               state_next.digit_count  = state.digit_count + 3'd1;
            end
         end else if (in_char == CHAR_ZERO_GROUP && state.digit_count == 3'd0) begin
            burst.word  = '0;
            burst.count = 3'd4;
         end else if (in_char == CHAR_END) begin
            case (state.digit_count)
               3'd1: begin
                  burst.count  = 3'd1;
                  burst.status = STATUS_SHORT_TAIL;
               end
               3'd2:    burst.count = 3'd1;
               3'd3:    burst.count = 3'd2;
               3'd4:    burst.count = 3'd3;
               default: burst.count = 3'd0;
            endcase
            state_next.group_value = '0;
            state_next.digit_count = 3'd0;
            state_next.stream_done = 1'b1;
         end else if (in_char != CHAR_SPACE) begin
            burst.word               = '0;
            burst.count              = 3'd1;
            burst.status             = STATUS_BAD_CHAR;
            state_next.group_value   = '0;
            state_next.digit_count   = 3'd0;
            state_next.stream_failed = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### dv/ascii85_decoder_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii85_decoder_unit_checker
// Decodes every accepted character on its own and compares each byte that
// leaves the decoder, in order, against the bytes that character should give.
// ----------------------------------------------------------------------------
module ascii85_decoder_unit_checker
   import a85d_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   a85d_req_if       req_mon,
   a85d_rsp_if       rsp_mon,
   output int        mismatch_count,
   output int        bytes_pending,
   output int        bytes_checked
);

   typedef struct packed {
      logic [7:0]      data_byte;
      a85d_status_type status;
      logic            last_of_run;
   } decoded_byte_type;

   decoded_byte_type bytes_due[$];

   logic [31:0] acc_value;
   logic [2:0]  acc_digits;
   logic        seen_end;
   logic        seen_error;
   int          mismatches;
   int          compared;

   task automatic queue_word(input logic [31:0] word, input int count,
                             input a85d_status_type st);
      for (int i = 0; i < count; i++) begin
         bytes_due.push_back('{word[31-8*i -: 8], st, (i == count - 1)});
      end
   endtask

   task automatic decode_char(input logic [7:0] ch);
      if (seen_end || seen_error) begin
         return;
      end
      if (ch >= CHAR_FIRST_DIGIT && ch <= CHAR_LAST_DIGIT) begin
         acc_value = acc_value * 32'(RADIX) + 32'(ch - CHAR_FIRST_DIGIT);
         if (acc_digits == 3'd4) begin
            queue_word(acc_value, 4, STATUS_NORMAL);
            acc_value  = '0;
            acc_digits = '0;
         end else begin
            acc_digits = acc_digits + 3'd1;
         end
      end else if (ch == CHAR_ZERO_GROUP && acc_digits == 3'd0) begin
         queue_word('0, 4, STATUS_NORMAL);
      end else if (ch == CHAR_END) begin
         // pad the missing digits by adding ones into the dropped low bytes, keep the full bytes
         case (acc_digits)
            3'd1: begin
               queue_word(acc_value * 32'(RADIX_P3) + 32'(PAD_THREE_BYTES), 1,
                          STATUS_SHORT_TAIL);
            end
            3'd2: begin
               queue_word(acc_value * 32'(RADIX_P3) + 32'(PAD_THREE_BYTES), 1,
                          STATUS_NORMAL);
            end
            3'd3: begin
               queue_word(acc_value * 32'(RADIX_P2) + 32'(PAD_TWO_BYTES), 2,
                          STATUS_NORMAL);
            end
            3'd4: begin
               queue_word(acc_value * 32'(RADIX) + 32'(PAD_ONE_BYTE), 3, STATUS_NORMAL);
            end
            default: ;
         endcase
         acc_value  = '0;
         acc_digits = '0;
         seen_end   = 1'b1;
      end else if (ch != CHAR_SPACE) begin
         bytes_due.push_back('{8'h00, STATUS_BAD_CHAR, 1'b1});
         acc_value  = '0;
         acc_digits = '0;
         seen_error = 1'b1;
      end
   endtask

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         bytes_due.delete();
         acc_value  = '0;
         acc_digits = '0;
         seen_end   = 1'b0;
         seen_error = 1'b0;
         mismatches = 0;
         compared   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bytes_due.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %02h status %0d last %0b",
                                       rsp_mon.data_byte, rsp_mon.status,
                                       rsp_mon.last_of_run));
            end else begin
               want = bytes_due.pop_front();
               compared++;
               if (rsp_mon.data_byte !== want.data_byte || rsp_mon.status !== want.status
                   || rsp_mon.last_of_run !== want.last_of_run) begin
                  note_mismatch($sformatf(
                     "byte mismatch: want %02h status %0d last %0b, got %02h status %0d last %0b",
                     want.data_byte, want.status, want.last_of_run,
                     rsp_mon.data_byte, rsp_mon.status, rsp_mon.last_of_run));
               end
            end
         end
         // a character never yields bytes on the edge that takes it
         if (req_mon.valid && req_mon.ready) begin
            decode_char(req_mon.in_char);
         end
      end
      mismatch_count <= mismatches;
      bytes_checked  <= compared;
      bytes_pending  <= bytes_due.size();
   end

endmodule

### dv/ascii85_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii85_decoder_unit_tb
// Feeds one long base-85 stream through the decoder under changing pacing on
// both sides, closes it by an end mark or a bad character, and reports the
// verdict from the checker's mismatch and pending-byte counts.
// ----------------------------------------------------------------------------
module ascii85_decoder_unit_tb;
   import a85d_pkg::*;

   localparam int RESET_CYCLES   = 9;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;

   a85d_req_if req_chan ();
   a85d_rsp_if rsp_chan ();

   int    mismatch_count;
   int    bytes_pending;
   int    bytes_checked;
   int    send_idle_pct;
   int    recv_idle_pct;
   int    holdoff_ticket;
   int    holdoff_seen;
   int    holdoff_left;
   int    idle_cycles;
   int    chars_sent;
   int    group_fill;
   string closing;

   always #6 clock = ~clock;

   ascii85_decoder_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   ascii85_decoder_unit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   // receiver: random stalls, or a long hold-off whenever a new one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holdoff_ticket != holdoff_seen) begin
         holdoff_seen   <= holdoff_ticket;
         holdoff_left   <= HOLDOFF_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left   <= holdoff_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
                  WATCHDOG_LIMIT, bytes_pending);
         $display("ascii85_decoder_unit regression: fail");
         $finish;
      end
   end

   task automatic set_pacing(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   task automatic send_char(input logic [7:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_char <= ch;
      do @(posedge clock); while (!req_chan.ready);
      chars_sent++;
      if (ch >= CHAR_FIRST_DIGIT && ch <= CHAR_LAST_DIGIT) begin
         group_fill = (group_fill == 4) ? 0 : group_fill + 1;
      end
   endtask

   // hold off new characters until every decoded byte has left
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_digit();
      return CHAR_FIRST_DIGIT + 8'($urandom_range(0, 84));
   endfunction

   // mostly digits; 'z' only at a group start so the stream stays alive
   function automatic logic [7:0] pick_stream_char(input int fill);
      int r = $urandom_range(0, 99);
      if (r < 10) begin
         return CHAR_SPACE;
      end
      if (r < 18 && fill == 0) begin
         return CHAR_ZERO_GROUP;
      end
      if (r < 24) begin
         return r[0] ? CHAR_FIRST_DIGIT : CHAR_LAST_DIGIT;
      end
      return random_digit();
   endfunction

   task automatic send_stream_chars(input int count);
      repeat (count) send_char(pick_stream_char(group_fill));
   endtask

   task automatic close_stream();
      int         how = $urandom_range(0, 6);
      logic [7:0] bad;
      case (how)
         0, 1, 2, 3, 4: begin
            while (group_fill != how) send_char(random_digit());
            send_char(CHAR_END);
            closing = $sformatf("an end mark after %0d tail digits", how);
         end
         5: begin
            if (group_fill == 0) begin
               send_char(random_digit());
            end
            send_char(CHAR_ZERO_GROUP);
            closing = "a zero-group mark inside a group";
         end
         default: begin
            do begin
               bad = 8'($urandom_range(0, 255));
            end while ((bad >= CHAR_FIRST_DIGIT && bad <= CHAR_LAST_DIGIT)
                       || bad == CHAR_ZERO_GROUP || bad == CHAR_END || bad == CHAR_SPACE);
            send_char(bad);
            closing = $sformatf("the bad character %02h", bad);
         end
      endcase
   endtask

   initial begin
      string directed;
      req_chan.valid   = 1'b0;
      req_chan.in_char = 8'h00;
      rsp_chan.ready   = 1'b0;
      holdoff_ticket   = 0;
      holdoff_seen     = 0;
      holdoff_left     = 0;
      idle_cycles      = 0;
      chars_sent       = 0;
      group_fill       = 0;
      closing          = "nothing";
      // zero group, all-top-digit group (wraps), 'z', space, all-ones word,
      // then a group with a space inside it
      directed = "!!!!!uuuuuz s8W-!Bl ^Fm";
      set_pacing(19, 79);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed.len(); i++) begin
         send_char(directed[i]);
      end
      drain();

      send_stream_chars(10);
      holdoff_ticket <= holdoff_ticket + 1;
      send_stream_chars(30);
      set_pacing(79, 19);
      send_stream_chars(35);
      set_pacing(0, 0);
      send_stream_chars(25);

      close_stream();
      // everything from here on must be dropped
      send_char(8'h00);
      send_char(8'hff);
      repeat (6) send_char(8'($urandom_range(0, 255)));
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d characters sent under three pacing mixes and a %0d-cycle hold-off",
               chars_sent, HOLDOFF_CYCLES);
      $display("Summary: %0d decoded bytes compared; stream closed by %s",
               bytes_checked, closing);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("ascii85_decoder_unit regression: pass");
      end else begin
         $display("%0d mismatches, %0d bytes never arrived", mismatch_count, bytes_pending);
         $display("ascii85_decoder_unit regression: fail");
      end
      $finish;
   end

endmodule
